// File: src/nnrs_pkg.sv
`timescale 1ns / 1ps

package nnrs_pkg;

  // Register and position widths
  localparam int DIM_W       = 12;
  localparam int POS_W       = 11;
  localparam int CH_W        = 8;
  localparam int PIX_W       = 3 * CH_W;
  localparam int MAX_WIDTH   = 2048;
  localparam int MAX_HEIGHT  = 2048;
  localparam int MAX_RATIO   = 16;
  localparam int RESULT_CAP  = 16;
  localparam int ADDR_W      = $clog2(MAX_WIDTH);
  localparam int CAP_W       = $clog2(RESULT_CAP);
  localparam int RATIO_W     = DIM_W + $clog2(MAX_RATIO) + 1;
  localparam int DIV_CNT_W   = $clog2(DIM_W + 1);
  localparam int CFG_IDX_W   = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT = 2'd3;

  // Input function codes
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_PIXEL  = 2'd0;
  localparam logic [1:0] STATUS_REJECT = 2'd1;
  localparam logic [1:0] STATUS_RATIO  = 2'd2;

  typedef struct packed {
    logic            func;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]  out_red;
    logic [CH_W-1:0]  out_green;
    logic [CH_W-1:0]  out_blue;
    logic [POS_W-1:0] target_column;
    logic [POS_W-1:0] target_row;
    logic             last_of_run;
    logic             frame_done;
    logic [1:0]       status;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_START,
    ST_DIV,
    ST_IDLE,
    ST_PROC,
    ST_EMIT,
    ST_FIN,
    ST_RDATA
  } state_t;

  // 0 reads as 1, anything above hi reads as hi
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] x;
    x = v;
    if (x == '0) x = DIM_W'(1);
    if (x > hi) x = hi;
    return x;
  endfunction

endpackage

// File: src/nearest_neighbor_rgb_scaler_core.sv
`timescale 1ns / 1ps

// Nearest-neighbor RGB scaler. Source pixels (func = pixel) come in raster
// order on the in_* channel; the target image leaves on the out_* channel,
// one target pixel per transaction, with its column and row. Rows that
// repeat a source row are replayed from an internal line store, one pixel
// per drain transaction (func = drain). A pixel sent during a replay comes
// back as a single reject transaction; an unsupported size ratio answers
// every input with a single ratio transaction.
// Sizes must be written on the cfg_* port only while the block is idle;
// the block does not enforce this. Every write restarts the frame and
// reruns the step-size divide. After reset or a config write, in_stall
// is high while the two 12-bit step divisions run (one bit per cycle).
// Then one input is handled at a time: a source pixel passes the process,
// emit (at most 16 copies) and finish states, a drain tick the process
// and line store read states, a reject or ratio result the process state.
// Results sit in an output register; while out_stall is high the block
// still takes the next input, then holds until the register frees up.
// Reset is synchronous; the line store is not cleared (a replay only reads
// entries written on the same row).
module nearest_neighbor_rgb_scaler_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  nnrs_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output nnrs_pkg::out_item_t            out_data,
  input  logic                           cfg_write,
  input  logic [nnrs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nnrs_pkg::DIM_W-1:0]     cfg_data
);

  localparam int DW = nnrs_pkg::DIM_W;
  localparam int PW = nnrs_pkg::POS_W;

  // Configuration
  logic [DW-1:0] sw, sh, tw, th;
  logic [DW-1:0] sw_next, sh_next, tw_next, th_next;

  // Stream state
  nnrs_pkg::state_t state, state_next;
  logic [PW-1:0] sc, sc_next;         // source column
  logic [PW-1:0] sr, sr_next;         // source row
  logic [DW-1:0] ncs, ncs_next;       // source column of next target column
  logic [PW-1:0] ce, ce_next;         // column error
  logic [PW-1:0] oc, oc_next;         // output column
  logic [DW-1:0] nrs, nrs_next;       // source row of next target row
  logic [PW-1:0] rerr, rerr_next;     // row error
  logic [PW-1:0] orow, orow_next;     // output row
  logic          replay, replay_next; // more target rows reuse the stored row
  logic [PW-1:0] rcol, rcol_next;     // replay column
  logic [PW-1:0] rsrc, rsrc_next;     // source row held in the line store
  logic [nnrs_pkg::CAP_W-1:0] k, k_next;
  logic          active, active_next;
  logic          out_valid_next;

  // Payload registers
  nnrs_pkg::in_item_t  item, item_next;
  nnrs_pkg::out_item_t out_next;

  // Divider hookup
  logic          div_start;
  logic          cdiv_busy, rdiv_busy;
  logic [DW-1:0] cq, rq;
  logic [PW-1:0] cr, rr;

  // Line store
  logic                        ram_we, ram_re;
  logic [nnrs_pkg::ADDR_W-1:0] ram_raddr;
  logic [nnrs_pkg::PIX_W-1:0]  ram_rdata;
  logic [nnrs_pkg::PIX_W-1:0]  pixel;

  // Datapath helpers
  logic                         load_ok;
  logic                         ratio_bad;
  logic [DW-1:0]                ce_sum, ce_new, ncs_new;
  logic                         c_carry;
  logic [DW-1:0]                re_sum, re_new, nrs_new, orow_inc;
  logic                         r_carry, adv_wrap;
  logic [DW-1:0]                oc_inc, sc_inc, sr_inc, rcol_inc;
  logic                         emit_ok, emit_more, emit_fd, rep_fd;
  logic [PW-1:0]                rc;

  nnrs_div u_cdiv (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (sw),
    .divisor   (tw),
    .busy      (cdiv_busy),
    .quotient  (cq),
    .remainder (cr)
  );

  nnrs_div u_rdiv (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (sh),
    .divisor   (th),
    .busy      (rdiv_busy),
    .quotient  (rq),
    .remainder (rr)
  );

  nnrs_ram #(
    .WIDTH (nnrs_pkg::PIX_W),
    .DEPTH (nnrs_pkg::MAX_WIDTH)
  ) u_row_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (oc),
    .wdata (pixel),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign pixel     = {item.in_red, item.in_green, item.in_blue};
  assign load_ok   = !out_valid || !out_stall;
  assign ratio_bad =
      (nnrs_pkg::RATIO_W'(tw) > nnrs_pkg::RATIO_W'(sw) * nnrs_pkg::RATIO_W'(nnrs_pkg::MAX_RATIO)) ||
      (nnrs_pkg::RATIO_W'(th) > nnrs_pkg::RATIO_W'(sh) * nnrs_pkg::RATIO_W'(nnrs_pkg::MAX_RATIO));

  // Column step: error accumulator, carry into the source column
  assign ce_sum  = {1'b0, ce} + {1'b0, cr};
  assign c_carry = ce_sum >= tw;
  assign ce_new  = c_carry ? ce_sum - tw : ce_sum;
  assign ncs_new = ncs + cq + DW'(c_carry);

  // Row step and the advance to the next target row
  assign re_sum   = {1'b0, rerr} + {1'b0, rr};
  assign r_carry  = re_sum >= th;
  assign re_new   = r_carry ? re_sum - th : re_sum;
  assign nrs_new  = nrs + rq + DW'(r_carry);
  assign orow_inc = {1'b0, orow} + DW'(1);
  assign adv_wrap = orow_inc >= th;

  assign oc_inc   = {1'b0, oc} + DW'(1);
  assign sc_inc   = {1'b0, sc} + DW'(1);
  assign sr_inc   = {1'b0, sr} + DW'(1);
  assign rcol_inc = {1'b0, rcol} + DW'(1);

  assign emit_ok   = ({1'b0, oc} < tw) && (ncs == {1'b0, sc});
  assign emit_more = (k != nnrs_pkg::CAP_W'(nnrs_pkg::RESULT_CAP - 1)) &&
                     (oc_inc < tw) && (ncs_new == {1'b0, sc});
  assign emit_fd   = (orow_inc == th) && (oc_inc == tw);
  assign rep_fd    = (orow_inc == th) && (rcol_inc == tw);
  assign rc        = ({1'b0, rcol} >= tw) ? '0 : rcol;

  assign in_stall = (state != nnrs_pkg::ST_IDLE);

  always_comb begin
    state_next     = state;
    sw_next        = sw;
    sh_next        = sh;
    tw_next        = tw;
    th_next        = th;
    sc_next        = sc;
    sr_next        = sr;
    ncs_next       = ncs;
    ce_next        = ce;
    oc_next        = oc;
    nrs_next       = nrs;
    rerr_next      = rerr;
    orow_next      = orow;
    replay_next    = replay;
    rcol_next      = rcol;
    rsrc_next      = rsrc;
    k_next         = k;
    active_next    = active;
    item_next      = item;
    out_next       = out_data;
    out_valid_next = out_valid && out_stall;
    div_start      = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_raddr      = rc;

    case (state)
      nnrs_pkg::ST_START: begin
        div_start  = 1'b1;
        state_next = nnrs_pkg::ST_DIV;
      end

      nnrs_pkg::ST_DIV: begin
        if (!cdiv_busy && !rdiv_busy) begin
          state_next = nnrs_pkg::ST_IDLE;
        end
      end

      nnrs_pkg::ST_IDLE: begin
        if (in_valid) begin
          item_next  = in_data;
          state_next = nnrs_pkg::ST_PROC;
        end
      end

      nnrs_pkg::ST_PROC: begin
        if (ratio_bad) begin
          if (load_ok) begin
            out_next             = '0;
            out_next.status      = nnrs_pkg::STATUS_RATIO;
            out_next.last_of_run = 1'b1;
            out_valid_next       = 1'b1;
            state_next           = nnrs_pkg::ST_IDLE;
          end
        end else if (item.func == nnrs_pkg::FUNC_DRAIN) begin
          if (!replay) begin
            state_next = nnrs_pkg::ST_IDLE;
          end else begin
            rcol_next  = rc;
            ram_re     = 1'b1;
            state_next = nnrs_pkg::ST_RDATA;
          end
        end else if (replay) begin
          if (load_ok) begin
            out_next             = '0;
            out_next.status      = nnrs_pkg::STATUS_REJECT;
            out_next.last_of_run = 1'b1;
            out_valid_next       = 1'b1;
            state_next           = nnrs_pkg::ST_IDLE;
          end
        end else begin
          active_next = ({1'b0, sr} == nrs) && (orow_inc <= th);
          k_next      = '0;
          state_next  = (({1'b0, sr} == nrs) && (orow_inc <= th)) ?
                        nnrs_pkg::ST_EMIT : nnrs_pkg::ST_FIN;
        end
      end

      nnrs_pkg::ST_EMIT: begin
        if (!emit_ok) begin
          state_next = nnrs_pkg::ST_FIN;
        end else if (load_ok) begin
          ram_we                 = 1'b1;
          out_next.out_red       = item.in_red;
          out_next.out_green     = item.in_green;
          out_next.out_blue      = item.in_blue;
          out_next.target_column = oc;
          out_next.target_row    = orow;
          out_next.last_of_run   = !emit_more;
          out_next.frame_done    = emit_fd;
          out_next.status        = nnrs_pkg::STATUS_PIXEL;
          out_valid_next         = 1'b1;
          oc_next                = oc_inc[PW-1:0];
          ncs_next               = ncs_new;
          ce_next                = ce_new[PW-1:0];
          k_next                 = k + nnrs_pkg::CAP_W'(1);
          if (!emit_more) begin
            state_next = nnrs_pkg::ST_FIN;
          end
        end
      end

      nnrs_pkg::ST_FIN: begin
        // end of one source pixel; end of an emitting row moves the target row on
        if (sc_inc >= sw) begin
          sc_next = '0;
          if (active) begin
            oc_next     = '0;
            ncs_next    = '0;
            ce_next     = '0;
            orow_next   = adv_wrap ? '0 : orow_inc[PW-1:0];
            nrs_next    = adv_wrap ? '0 : nrs_new;
            rerr_next   = adv_wrap ? '0 : re_new[PW-1:0];
            replay_next = !adv_wrap && (nrs_new == {1'b0, sr});
            rcol_next   = '0;
            rsrc_next   = sr;
          end
          sr_next = (sr_inc >= sh) ? '0 : sr_inc[PW-1:0];
        end else begin
          sc_next = sc_inc[PW-1:0];
        end
        state_next = nnrs_pkg::ST_IDLE;
      end

      nnrs_pkg::ST_RDATA: begin
        if (load_ok) begin
          out_next.out_red       = ram_rdata[nnrs_pkg::PIX_W-1 -: nnrs_pkg::CH_W];
          out_next.out_green     = ram_rdata[nnrs_pkg::CH_W +: nnrs_pkg::CH_W];
          out_next.out_blue      = ram_rdata[nnrs_pkg::CH_W-1:0];
          out_next.target_column = rcol;
          out_next.target_row    = orow;
          out_next.last_of_run   = 1'b1;
          out_next.frame_done    = rep_fd;
          out_next.status        = nnrs_pkg::STATUS_PIXEL;
          out_valid_next         = 1'b1;
          if (rcol_inc >= tw) begin
            rcol_next   = '0;
            orow_next   = adv_wrap ? '0 : orow_inc[PW-1:0];
            nrs_next    = adv_wrap ? '0 : nrs_new;
            rerr_next   = adv_wrap ? '0 : re_new[PW-1:0];
            replay_next = !adv_wrap && (nrs_new == {1'b0, rsrc});
          end else begin
            rcol_next = rcol_inc[PW-1:0];
          end
          state_next = nnrs_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = nnrs_pkg::ST_START;
      end
    endcase

    // A register write clamps the value and restarts the frame
    if (cfg_write) begin
      case (cfg_index)
        nnrs_pkg::REG_SOURCE_WIDTH:
          sw_next = nnrs_pkg::clamp_dim(cfg_data, DW'(nnrs_pkg::MAX_WIDTH));
        nnrs_pkg::REG_SOURCE_HEIGHT:
          sh_next = nnrs_pkg::clamp_dim(cfg_data, DW'(nnrs_pkg::MAX_HEIGHT));
        nnrs_pkg::REG_TARGET_WIDTH:
          tw_next = nnrs_pkg::clamp_dim(cfg_data, DW'(nnrs_pkg::MAX_WIDTH));
        nnrs_pkg::REG_TARGET_HEIGHT:
          th_next = nnrs_pkg::clamp_dim(cfg_data, DW'(nnrs_pkg::MAX_HEIGHT));
        default: begin
        end
      endcase
      sc_next     = '0;
      sr_next     = '0;
      ncs_next    = '0;
      ce_next     = '0;
      oc_next     = '0;
      nrs_next    = '0;
      rerr_next   = '0;
      orow_next   = '0;
      replay_next = 1'b0;
      rcol_next   = '0;
      state_next  = nnrs_pkg::ST_START;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= nnrs_pkg::ST_START;
      sw        <= DW'(1);
      sh        <= DW'(1);
      tw        <= DW'(1);
      th        <= DW'(1);
      sc        <= '0;
      sr        <= '0;
      ncs       <= '0;
      ce        <= '0;
      oc        <= '0;
      nrs       <= '0;
      rerr      <= '0;
      orow      <= '0;
      replay    <= 1'b0;
      rcol      <= '0;
      rsrc      <= '0;
      k         <= '0;
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      sw        <= sw_next;
      sh        <= sh_next;
      tw        <= tw_next;
      th        <= th_next;
      sc        <= sc_next;
      sr        <= sr_next;
      ncs       <= ncs_next;
      ce        <= ce_next;
      oc        <= oc_next;
      nrs       <= nrs_next;
      rerr      <= rerr_next;
      orow      <= orow_next;
      replay    <= replay_next;
      rcol      <= rcol_next;
      rsrc      <= rsrc_next;
      k         <= k_next;
      active    <= active_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    item     <= item_next;
    out_data <= out_next;
  end

endmodule

// File: src/nnrs_ram.sv
`timescale 1ns / 1ps

module nnrs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/nnrs_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module nnrs_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [nnrs_pkg::DIM_W-1:0]  dividend,
  input  logic [nnrs_pkg::DIM_W-1:0]  divisor,
  output logic                        busy,
  output logic [nnrs_pkg::DIM_W-1:0]  quotient,
  output logic [nnrs_pkg::POS_W-1:0]  remainder
);

  logic [nnrs_pkg::DIM_W-1:0]     rem;
  logic [nnrs_pkg::DIM_W-1:0]     quo;
  logic [nnrs_pkg::DIV_CNT_W-1:0] cnt;
  logic [nnrs_pkg::DIM_W:0]       shifted;
  logic [nnrs_pkg::DIM_W:0]       diff;
  logic                           fits;

  assign shifted = {rem, quo[nnrs_pkg::DIM_W-1]};
  assign fits    = shifted >= {1'b0, divisor};
  assign diff    = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= nnrs_pkg::DIV_CNT_W'(nnrs_pkg::DIM_W);
    end else if (busy) begin
      cnt <= cnt - nnrs_pkg::DIV_CNT_W'(1);
      if (cnt == nnrs_pkg::DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[nnrs_pkg::DIM_W-1:0] : shifted[nnrs_pkg::DIM_W-1:0];
      quo <= {quo[nnrs_pkg::DIM_W-2:0], fits};
    end
  end

  // remainder is always below the divisor, which is at most 2048
  assign quotient  = quo;
  assign remainder = rem[nnrs_pkg::POS_W-1:0];

endmodule
